>>> hdl/lmk_pkg.sv
// shared types, constants and helpers for the output level mapper with kick
// no dependencies
package lmk_pkg;

  localparam int LEVEL_FRACTION_BITS = 10;
  localparam int DUTY_BITS = 10;

  localparam int LEVEL_W = LEVEL_FRACTION_BITS + 1;
  localparam int RAW_W = 12;
  localparam int KICK_W = 16;
  localparam int KIND_W = 2;
  localparam int ORDER_W = 6;
  localparam int SEL_W = 2;
  localparam int OP_W = 2;
  localparam int BYTE_W = 8;
  localparam int NUM_W = 2 * LEVEL_FRACTION_BITS + 1;
  localparam int PROD_W = NUM_W + DUTY_BITS + 2;
  localparam int BYTE_PROD_W = LEVEL_W + 10;
  localparam int CLAMP_W = (LEVEL_W > RAW_W) ? LEVEL_W : RAW_W;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam int IN_FIELDS_W = 3 * RAW_W;
  localparam int IN_TDATA_W = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = DUTY_BITS + 3 * BYTE_W + 2;
  localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [LEVEL_W-1:0] LEVEL_ONE = LEVEL_W'(1) << LEVEL_FRACTION_BITS;
  localparam logic [LEVEL_W-1:0] LEVEL_HALF = LEVEL_W'(1) << (LEVEL_FRACTION_BITS - 1);

  typedef enum logic [OP_W-1:0] {
    OP_SET  = 2'd0,
    OP_TICK = 2'd1,
    OP_SAFE = 2'd2
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_PWM   = 2'd0,
    KIND_STRIP = 2'd1,
    KIND_RELAY = 2'd2
  } kind_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DEVICE_KIND   = 3'd0,
    REG_DUTY_FLOOR    = 3'd1,
    REG_KICK_TICKS    = 3'd2,
    REG_SAFE_LEVEL    = 3'd3,
    REG_PIN_POLARITY  = 3'd4,
    REG_CHANNEL_ORDER = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [KIND_W-1:0]  device_kind;
    logic [LEVEL_W-1:0] duty_floor;
    logic [KICK_W-1:0]  kick_ticks;
    logic [LEVEL_W-1:0] safe_level;
    logic               pin_polarity;
    logic [ORDER_W-1:0] channel_order;
  } cfg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] held_a;
    logic [LEVEL_W-1:0] held_b;
    logic [LEVEL_W-1:0] held_c;
    logic               kicking;
  } view_t;

  typedef struct packed {
    logic               kick_active;
    logic               relay_pin;
    logic [BYTE_W-1:0]  blue_out;
    logic [BYTE_W-1:0]  green_out;
    logic [BYTE_W-1:0]  red_out;
    logic [DUTY_BITS-1:0] pwm_duty;
  } result_t;

  // negative levels go to zero, anything above one is limited to one
  function automatic logic [LEVEL_W-1:0] clamp_level(input logic [RAW_W-1:0] raw);
    logic [CLAMP_W-1:0] wide;
    logic [CLAMP_W-1:0] one_wide;
    wide = CLAMP_W'(raw[RAW_W-2:0]);
    one_wide = CLAMP_W'(LEVEL_ONE);
    if (raw[RAW_W-1]) begin
      clamp_level = '0;
    end else if (wide > one_wide) begin
      clamp_level = LEVEL_ONE;
    end else begin
      clamp_level = wide[LEVEL_W-1:0];
    end
  endfunction

endpackage

>>> hdl/lmk_state.sv
// held levels, previous level and kick counter, updated per input transaction
// depends on lmk_pkg
module lmk_state (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [lmk_pkg::OP_W-1:0]      op,
  input  logic [lmk_pkg::RAW_W-1:0]     level_a,
  input  logic [lmk_pkg::RAW_W-1:0]     level_b,
  input  logic [lmk_pkg::RAW_W-1:0]     level_c,
  input  lmk_pkg::cfg_t                 cfg,
  output lmk_pkg::view_t                view_next
);

  logic [lmk_pkg::LEVEL_W-1:0] held_a, held_b, held_c;
  logic [lmk_pkg::LEVEL_W-1:0] held_a_next, held_b_next, held_c_next;
  logic [lmk_pkg::LEVEL_W-1:0] previous_level, previous_level_next;
  logic [lmk_pkg::KICK_W-1:0]  kick_remaining, kick_remaining_next;
  logic                        apply;

  always_comb begin
    held_a_next = held_a;
    held_b_next = held_b;
    held_c_next = held_c;
    previous_level_next = previous_level;
    kick_remaining_next = kick_remaining;
    apply = 1'b0;
    case (op)
      lmk_pkg::OP_SET: begin
        held_a_next = lmk_pkg::clamp_level(level_a);
        held_b_next = lmk_pkg::clamp_level(level_b);
        held_c_next = lmk_pkg::clamp_level(level_c);
        apply = 1'b1;
      end
      lmk_pkg::OP_TICK: begin
        if (kick_remaining != '0) begin
          kick_remaining_next = kick_remaining - lmk_pkg::KICK_W'(1);
        end
      end
      lmk_pkg::OP_SAFE: begin
        held_a_next = '0;
        held_b_next = '0;
        held_c_next = '0;
        if (cfg.device_kind != lmk_pkg::KIND_STRIP) begin
          held_a_next = (cfg.safe_level > lmk_pkg::LEVEL_ONE) ?
                        lmk_pkg::LEVEL_ONE : cfg.safe_level;
        end
        apply = 1'b1;
      end
      default: begin
      end
    endcase
    // kick logic only for the dimmed kind
    if (apply && (cfg.device_kind == lmk_pkg::KIND_PWM)) begin
      if ((held_a_next != '0) && (cfg.kick_ticks != '0) && (previous_level == '0)) begin
        kick_remaining_next = cfg.kick_ticks;
      end
      if (held_a_next == '0) begin
        kick_remaining_next = '0;
      end
      previous_level_next = held_a_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_a <= '0;
      held_b <= '0;
      held_c <= '0;
      previous_level <= '0;
      kick_remaining <= '0;
    end else if (accept) begin
      held_a <= held_a_next;
      held_b <= held_b_next;
      held_c <= held_c_next;
      previous_level <= previous_level_next;
      kick_remaining <= kick_remaining_next;
    end
  end

  assign view_next.held_a = held_a_next;
  assign view_next.held_b = held_b_next;
  assign view_next.held_c = held_c_next;
  assign view_next.kicking = (kick_remaining_next != '0);

endmodule

>>> hdl/lmk_report.sv
// drive values for the configured kind from the levels after a transaction
// depends on lmk_pkg
module lmk_report (
  input  lmk_pkg::cfg_t    cfg,
  input  lmk_pkg::view_t   view,
  output lmk_pkg::result_t result
);

  logic [lmk_pkg::LEVEL_W-1:0]     span;
  logic [2*lmk_pkg::LEVEL_W-1:0]   lifted;
  logic [lmk_pkg::NUM_W-1:0]       num;
  logic [lmk_pkg::PROD_W-1:0]      scaled;
  logic [lmk_pkg::PROD_W-1:0]      rounded;
  logic [lmk_pkg::DUTY_BITS-1:0]   duty;
  logic [lmk_pkg::BYTE_W-1:0]      byte_a, byte_b, byte_c;
  logic [lmk_pkg::SEL_W-1:0]       sel_r, sel_g, sel_b;
  logic                            order_ok;

  // round(level * 255 / one)
  function automatic logic [lmk_pkg::BYTE_W-1:0] byte_of(
    input logic [lmk_pkg::LEVEL_W-1:0] lvl
  );
    logic [lmk_pkg::BYTE_PROD_W-1:0] p;
    p = (lmk_pkg::BYTE_PROD_W'(lvl) << 9) - (lmk_pkg::BYTE_PROD_W'(lvl) << 1)
        + lmk_pkg::BYTE_PROD_W'(lmk_pkg::LEVEL_ONE);
    byte_of = lmk_pkg::BYTE_W'(p >> (lmk_pkg::LEVEL_FRACTION_BITS + 1));
  endfunction

  function automatic logic [lmk_pkg::BYTE_W-1:0] pick(
    input logic [lmk_pkg::SEL_W-1:0] s,
    input logic [lmk_pkg::BYTE_W-1:0] a,
    input logic [lmk_pkg::BYTE_W-1:0] b,
    input logic [lmk_pkg::BYTE_W-1:0] c
  );
    case (s)
      2'd0: pick = a;
      2'd1: pick = b;
      default: pick = c;
    endcase
  endfunction

  always_comb begin
    span = lmk_pkg::LEVEL_ONE - cfg.duty_floor;
    lifted = view.held_a * span;
    if (view.kicking || (cfg.duty_floor >= lmk_pkg::LEVEL_ONE)) begin
      num = lmk_pkg::NUM_W'(1) << (2 * lmk_pkg::LEVEL_FRACTION_BITS);
    end else begin
      num = (lmk_pkg::NUM_W'(cfg.duty_floor) << lmk_pkg::LEVEL_FRACTION_BITS)
            + lmk_pkg::NUM_W'(lifted);
    end
    // num * 2 * (2^duty_bits - 1) by shift and subtract
    scaled = (lmk_pkg::PROD_W'(num) << (lmk_pkg::DUTY_BITS + 1))
             - (lmk_pkg::PROD_W'(num) << 1);
    rounded = (scaled + (lmk_pkg::PROD_W'(1) << (2 * lmk_pkg::LEVEL_FRACTION_BITS)))
              >> (2 * lmk_pkg::LEVEL_FRACTION_BITS + 1);
    duty = (view.held_a == '0) ? '0 : rounded[lmk_pkg::DUTY_BITS-1:0];
  end

  always_comb begin
    byte_a = byte_of(view.held_a);
    byte_b = byte_of(view.held_b);
    byte_c = byte_of(view.held_c);
    sel_r = cfg.channel_order[1:0];
    sel_g = cfg.channel_order[3:2];
    sel_b = cfg.channel_order[5:4];
    order_ok = (sel_r != 2'd3) && (sel_g != 2'd3) && (sel_b != 2'd3) &&
               (sel_r != sel_g) && (sel_r != sel_b) && (sel_g != sel_b);
    if (!order_ok) begin
      sel_r = 2'd0;
      sel_g = 2'd1;
      sel_b = 2'd2;
    end
  end

  always_comb begin
    result = '0;
    case (cfg.device_kind)
      lmk_pkg::KIND_PWM: begin
        result.pwm_duty = duty;
        result.kick_active = view.kicking;
      end
      lmk_pkg::KIND_STRIP: begin
        result.red_out = pick(sel_r, byte_a, byte_b, byte_c);
        result.green_out = pick(sel_g, byte_a, byte_b, byte_c);
        result.blue_out = pick(sel_b, byte_a, byte_b, byte_c);
      end
      lmk_pkg::KIND_RELAY: begin
        result.relay_pin = ((view.held_a >= lmk_pkg::LEVEL_HALF) == cfg.pin_polarity);
      end
      default: begin
      end
    endcase
  end

endmodule

>>> hdl/output_level_mapper_with_kick.sv
// top level: configuration registers, state update, result mapping and output register
// depends on lmk_pkg, lmk_state, lmk_report
//
// One input transaction (set levels, millisecond tick or safe) is taken per clock
// and gives exactly one result transaction, registered in the following cycle. The state
// update and the duty, byte and relay mapping are one pass of logic in front of the
// output register, so the sustained rate is one item per cycle; the input is held
// off only while a result sits in the output register and the downstream side
// does not take it. Configuration writes are always accepted and take effect on
// the next input transaction.
module output_level_mapper_with_kick (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // level_a, level_b, level_c from bit 0, zero filled
  input  logic [lmk_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // op
  input  logic [lmk_pkg::OP_W-1:0]           s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // pwm_duty, red_out, green_out, blue_out, relay_pin, kick_active from bit 0
  output logic [lmk_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lmk_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [lmk_pkg::CFG_DATA_W-1:0]     cfg_data
);

  lmk_pkg::cfg_t    cfg;
  lmk_pkg::view_t   view_next;
  lmk_pkg::result_t result;
  logic             accept;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.device_kind <= lmk_pkg::KIND_PWM;
      cfg.duty_floor <= '0;
      cfg.kick_ticks <= '0;
      cfg.safe_level <= '0;
      cfg.pin_polarity <= 1'b1;
      cfg.channel_order <= lmk_pkg::ORDER_W'(36);
    end else if (cfg_valid) begin
      case (cfg_index)
        lmk_pkg::REG_DEVICE_KIND:   cfg.device_kind <= cfg_data[lmk_pkg::KIND_W-1:0];
        lmk_pkg::REG_DUTY_FLOOR:    cfg.duty_floor <= cfg_data[lmk_pkg::LEVEL_W-1:0];
        lmk_pkg::REG_KICK_TICKS:    cfg.kick_ticks <= cfg_data[lmk_pkg::KICK_W-1:0];
        lmk_pkg::REG_SAFE_LEVEL:    cfg.safe_level <= cfg_data[lmk_pkg::LEVEL_W-1:0];
        lmk_pkg::REG_PIN_POLARITY:  cfg.pin_polarity <= cfg_data[0];
        lmk_pkg::REG_CHANNEL_ORDER: cfg.channel_order <= cfg_data[lmk_pkg::ORDER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept = s_axis_tvalid && s_axis_tready;

  lmk_state u_state (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .op        (s_axis_tuser),
    .level_a   (s_axis_tdata[lmk_pkg::RAW_W-1:0]),
    .level_b   (s_axis_tdata[2*lmk_pkg::RAW_W-1:lmk_pkg::RAW_W]),
    .level_c   (s_axis_tdata[3*lmk_pkg::RAW_W-1:2*lmk_pkg::RAW_W]),
    .cfg       (cfg),
    .view_next (view_next)
  );

  lmk_report u_report (
    .cfg    (cfg),
    .view   (view_next),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tdata <= lmk_pkg::OUT_TDATA_W'(result);
    end
  end

endmodule
